// ===== hw/rtl/mrs_pkg.sv =====
`timescale 1ns / 1ps

package mrs_pkg;

  localparam int unsigned XLEN           = 32;
  localparam int unsigned NREGS          = 32;
  localparam int unsigned REG_AW         = 5;
  localparam int unsigned DATA_WORDS_DEF = 16384;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [31:0] RESET_PC  = 32'hBFC0_0000;
  localparam logic [31:0] VEC_BEV   = 32'hBFC0_0180;
  localparam logic [31:0] VEC_NORM  = 32'h8000_0080;
  localparam logic [31:0] BD_BIT    = 32'h8000_0000;
  localparam logic [31:0] CODE_MASK = 32'h0000_007C;
  localparam logic [31:0] MODE_MASK = 32'h0000_003F;
  localparam logic [31:0] PC_HI     = 32'hF000_0000;
  localparam logic [31:0] TGT_MASK  = 32'h03FF_FFFF;
  localparam logic [31:0] ONES      = 32'hFFFF_FFFF;
  localparam int unsigned BEV_BIT   = 22;

  // COP0 register numbers
  localparam logic [4:0] C0_BADVADDR = 5'd8;
  localparam logic [4:0] C0_STATUS   = 5'd12;
  localparam logic [4:0] C0_CAUSE    = 5'd13;
  localparam logic [4:0] C0_EPC      = 5'd14;
  localparam logic [4:0] LINK_REG    = 5'd31;

  // Cause codes
  localparam logic [4:0] CAUSE_ADEL = 5'd4;
  localparam logic [4:0] CAUSE_ADES = 5'd5;
  localparam logic [4:0] CAUSE_SYS  = 5'd8;
  localparam logic [4:0] CAUSE_BP   = 5'd9;
  localparam logic [4:0] CAUSE_RI   = 5'd10;
  localparam logic [4:0] CAUSE_OV   = 5'd12;

  typedef enum logic [2:0] {
    EXC_NONE = 3'd0,
    EXC_ADEL = 3'd1,
    EXC_ADES = 3'd2,
    EXC_SYS  = 3'd3,
    EXC_BP   = 3'd4,
    EXC_RI   = 3'd5,
    EXC_OV   = 3'd6
  } exc_kind_e;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2A;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_SWR     = 6'h2E;

  // SPECIAL functions
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  // REGIMM and COP0 forms
  localparam logic [4:0] RI_BLTZ    = 5'h00;
  localparam logic [4:0] RI_BGEZ    = 5'h01;
  localparam logic [4:0] RI_BLTZAL  = 5'h10;
  localparam logic [4:0] RI_BGEZAL  = 5'h11;
  localparam logic [4:0] CO_MF      = 5'h00;
  localparam logic [4:0] CO_MT      = 5'h04;
  localparam logic [4:0] CO_CO      = 5'h10;
  localparam logic [5:0] CO_FN_RFE  = 6'h10;

  // Classified instruction handed from front to back
  typedef struct packed {
    logic [31:0] ins;
    logic        rsvd;
    logic        is_div;
    logic        is_mul;
  } dec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_EXEC,
    BK_DIV,
    BK_LOADW
  } bk_state_e;

endpackage

// ===== hw/rtl/mrs_in_if.sv =====
`timescale 1ns / 1ps

interface mrs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

// ===== hw/rtl/mrs_out_if.sv =====
`timescale 1ns / 1ps

interface mrs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fetch_pc;
  logic [2:0]  exception_kind;
  logic [4:0]  reg_written;
  logic [31:0] reg_value;
  logic        store_valid;
  logic [31:0] store_address;
  logic [31:0] store_data;

  modport source (output valid, output fetch_pc, output exception_kind, output reg_written,
                  output reg_value, output store_valid, output store_address,
                  output store_data, input ready);
  modport sink (input valid, input fetch_pc, input exception_kind, input reg_written,
                input reg_value, input store_valid, input store_address,
                input store_data, output ready);
endinterface

// ===== hw/rtl/mrs_ram.sv =====
`timescale 1ns / 1ps

module mrs_ram #(
  parameter int unsigned WIDTH = mrs_pkg::XLEN,
  parameter int unsigned DEPTH = mrs_pkg::NREGS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word with a registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mrs_front.sv =====
`timescale 1ns / 1ps

module mrs_front (
  mrs_in_if.sink       item_i,
  input  logic         full_i,
  output logic         push_o,
  output mrs_pkg::dec_t dec_o
);

  logic [5:0] op;
  logic [5:0] fn;
  logic [4:0] rs;
  logic [4:0] rt;
  logic       rsvd;

  assign op = item_i.instruction_word[31:26];
  assign rs = item_i.instruction_word[25:21];
  assign rt = item_i.instruction_word[20:16];
  assign fn = item_i.instruction_word[5:0];

  // Flag encodings the back end must trap on
  always_comb begin
    rsvd = 1'b0;
    case (op)
      mrs_pkg::OP_SPECIAL: begin
        rsvd = !(fn inside {mrs_pkg::FN_SLL, mrs_pkg::FN_SRL, mrs_pkg::FN_SRA,
                            mrs_pkg::FN_SLLV, mrs_pkg::FN_SRLV, mrs_pkg::FN_SRAV,
                            mrs_pkg::FN_JR, mrs_pkg::FN_JALR, mrs_pkg::FN_SYSCALL,
                            mrs_pkg::FN_BREAK, mrs_pkg::FN_MFHI, mrs_pkg::FN_MTHI,
                            mrs_pkg::FN_MFLO, mrs_pkg::FN_MTLO, mrs_pkg::FN_MULT,
                            mrs_pkg::FN_MULTU, mrs_pkg::FN_DIV, mrs_pkg::FN_DIVU,
                            [mrs_pkg::FN_ADD:mrs_pkg::FN_NOR], mrs_pkg::FN_SLT,
                            mrs_pkg::FN_SLTU});
      end
      mrs_pkg::OP_REGIMM: begin
        rsvd = !(rt inside {mrs_pkg::RI_BLTZ, mrs_pkg::RI_BGEZ, mrs_pkg::RI_BLTZAL,
                            mrs_pkg::RI_BGEZAL});
      end
      mrs_pkg::OP_COP0: begin
        rsvd = !((rs == mrs_pkg::CO_MF) || (rs == mrs_pkg::CO_MT) ||
                 ((rs == mrs_pkg::CO_CO) && (fn == mrs_pkg::CO_FN_RFE)));
      end
      default: begin
        rsvd = !(op inside {[mrs_pkg::OP_J:mrs_pkg::OP_LUI], [mrs_pkg::OP_LB:mrs_pkg::OP_LWR],
                            [mrs_pkg::OP_SB:mrs_pkg::OP_SW], mrs_pkg::OP_SWR});
      end
    endcase
  end

  assign dec_o.ins    = item_i.instruction_word;
  assign dec_o.rsvd   = rsvd;
  assign dec_o.is_div = (op == mrs_pkg::OP_SPECIAL) &&
                        ((fn == mrs_pkg::FN_DIV) || (fn == mrs_pkg::FN_DIVU));
  assign dec_o.is_mul = (op == mrs_pkg::OP_SPECIAL) &&
                        ((fn == mrs_pkg::FN_MULT) || (fn == mrs_pkg::FN_MULTU));

  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

endmodule

// ===== hw/rtl/mrs_queue.sv =====
`timescale 1ns / 1ps

module mrs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mrs_pkg::dec_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output mrs_pkg::dec_t data_o
);

  localparam int unsigned PW = $clog2(mrs_pkg::QUEUE_DEPTH);

  mrs_pkg::dec_t    slot_q [mrs_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(mrs_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rptr_q];

  // Advance pointers on push and pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  // Hold the classified beats
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/mrs_div.sv =====
`timescale 1ns / 1ps

module mrs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  localparam int unsigned CW = $clog2(mrs_pkg::XLEN);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   rem_q, quo_q, dvs_q;
  logic [32:0]   trial;
  logic [32:0]   diff;
  logic          ge;

  // One restoring step per cycle
  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(mrs_pkg::XLEN - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/mrs_back.sv =====
`timescale 1ns / 1ps

module mrs_back #(
  parameter int unsigned DATA_WORDS = mrs_pkg::DATA_WORDS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  mrs_pkg::dec_t head_i,
  output logic          pop_o,
  mrs_out_if.source     result_o
);

  localparam int unsigned DAW = $clog2(DATA_WORDS);

  mrs_pkg::bk_state_e state_q, state_d;

  // Instruction being executed
  mrs_pkg::dec_t dec_q;
  logic [31:0]   ins;
  logic [5:0]    op, fn;
  logic [4:0]    rs, rt, rd, sa;
  logic [31:0]   imm, simm;
  assign ins  = dec_q.ins;
  assign op   = ins[31:26];
  assign rs   = ins[25:21];
  assign rt   = ins[20:16];
  assign rd   = ins[15:11];
  assign sa   = ins[10:6];
  assign fn   = ins[5:0];
  assign imm  = {16'h0, ins[15:0]};
  assign simm = {{16{ins[15]}}, ins[15:0]};

  // Architectural state
  logic [31:0] hi_q, lo_q, pc_q, bd_q, ld_val_q, ap_val_q;
  logic        bw_q, lw_q, ap_q;
  logic [4:0]  ld_reg_q, ap_reg_q;
  logic [31:0] cop0_q [mrs_pkg::NREGS];
  logic [mrs_pkg::NREGS-1:0] rf_vld_q;

  // Operand registers
  logic [31:0] a_q, b_q, addr_q;
  logic [63:0] prod_q;

  // Memory ports
  logic [4:0]     rf_raddr_a, rf_raddr_b, rf_waddr;
  logic [31:0]    rf_rdata_a, rf_rdata_b, rf_wdata, dm_rdata;
  logic           rf_we, dm_we;
  logic [DAW-1:0] dm_raddr;

  // Read stage values
  logic [31:0] a_rd, b_rd, addr_rd;
  logic        mul_sgn;
  logic [65:0] prod_full;

  // Execute stage values
  logic [31:0] npc, sum, dif, r_addi, word;
  logic [4:0]  lane, lane_l;
  logic [4:0]  x_wr_reg, x_ld_reg, x_code;
  logic [31:0] x_wr_val, x_ld_val, x_nt, x_st_data, x_hi, x_lo;
  logic        x_ld, x_nb, x_st, x_bad, x_hi_we, x_lo_we, x_c0_we, x_rfe, x_apply;
  mrs_pkg::exc_kind_e x_exc;
  logic [31:0] cause_new, status_push, status_rfe, vec;

  // Divider hook-up
  logic        div_start, div_done, div_sgn;
  logic [31:0] div_quo, div_rem, mag_a, mag_b, q_fix, r_fix;

  // Result register
  logic        out_valid_q;
  logic [31:0] o_pc_q, o_val_q, o_saddr_q, o_sdata_q;
  logic [2:0]  o_kind_q;
  logic [4:0]  o_reg_q;
  logic        o_st_q;

  mrs_ram #(.WIDTH(mrs_pkg::XLEN), .DEPTH(mrs_pkg::NREGS)) u_rf_a (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr_a), .rdata_o(rf_rdata_a)
  );

  mrs_ram #(.WIDTH(mrs_pkg::XLEN), .DEPTH(mrs_pkg::NREGS)) u_rf_b (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr_b), .rdata_o(rf_rdata_b)
  );

  mrs_ram #(.WIDTH(mrs_pkg::XLEN), .DEPTH(DATA_WORDS)) u_dmem (
    .clk_i, .we_i(dm_we), .waddr_i(addr_q[2 +: DAW]), .wdata_i(x_st_data),
    .raddr_i(dm_raddr), .rdata_o(dm_rdata)
  );

  mrs_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(mag_a), .divisor_i(mag_b),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  // Read stage: unwritten registers read as zero
  assign a_rd      = rf_vld_q[rs] ? rf_rdata_a : '0;
  assign b_rd      = rf_vld_q[rt] ? rf_rdata_b : '0;
  assign addr_rd   = a_rd + simm;
  assign mul_sgn   = (fn == mrs_pkg::FN_MULT);
  assign prod_full = $signed({mul_sgn & a_rd[31], a_rd}) * $signed({mul_sgn & b_rd[31], b_rd});

  // Divider operands and sign fix-up
  assign div_sgn = (fn == mrs_pkg::FN_DIV);
  assign mag_a   = (div_sgn && a_q[31]) ? (~a_q + 32'd1) : a_q;
  assign mag_b   = (div_sgn && b_q[31]) ? (~b_q + 32'd1) : b_q;
  assign q_fix   = (div_sgn && (a_q[31] ^ b_q[31])) ? (~div_quo + 32'd1) : div_quo;
  assign r_fix   = (div_sgn && a_q[31]) ? (~div_rem + 32'd1) : div_rem;

  // Execute stage
  assign npc    = pc_q + 32'd4;
  assign sum    = a_q + b_q;
  assign dif    = a_q - b_q;
  assign r_addi = a_q + simm;
  assign word   = dm_rdata;
  assign lane   = {addr_q[1:0], 3'b000};
  assign lane_l = 5'd24 - lane;

  always_comb begin
    x_wr_reg  = '0;
    x_wr_val  = '0;
    x_ld      = 1'b0;
    x_ld_reg  = rt;
    x_ld_val  = '0;
    x_nb      = 1'b0;
    x_nt      = '0;
    x_st      = 1'b0;
    x_st_data = '0;
    x_exc     = mrs_pkg::EXC_NONE;
    x_code    = '0;
    x_bad     = 1'b0;
    x_hi_we   = 1'b0;
    x_lo_we   = 1'b0;
    x_hi      = prod_q[63:32];
    x_lo      = prod_q[31:0];
    x_c0_we   = 1'b0;
    x_rfe     = 1'b0;
    if (dec_q.rsvd) begin
      x_exc  = mrs_pkg::EXC_RI;
      x_code = mrs_pkg::CAUSE_RI;
    end else begin
      case (op)
        mrs_pkg::OP_SPECIAL: begin
          x_wr_reg = rd;
          case (fn)
            mrs_pkg::FN_SLL:  x_wr_val = b_q << sa;
            mrs_pkg::FN_SRL:  x_wr_val = b_q >> sa;
            mrs_pkg::FN_SRA:  x_wr_val = 32'($signed(b_q) >>> sa);
            mrs_pkg::FN_SLLV: x_wr_val = b_q << a_q[4:0];
            mrs_pkg::FN_SRLV: x_wr_val = b_q >> a_q[4:0];
            mrs_pkg::FN_SRAV: x_wr_val = 32'($signed(b_q) >>> a_q[4:0]);
            mrs_pkg::FN_JR: begin
              x_wr_reg = '0;
              x_nb     = 1'b1;
              x_nt     = a_q;
            end
            mrs_pkg::FN_JALR: begin
              x_wr_reg = (rd != '0) ? rd : mrs_pkg::LINK_REG;
              x_wr_val = pc_q + 32'd8;
              x_nb     = 1'b1;
              x_nt     = a_q;
            end
            mrs_pkg::FN_SYSCALL: begin
              x_exc  = mrs_pkg::EXC_SYS;
              x_code = mrs_pkg::CAUSE_SYS;
            end
            mrs_pkg::FN_BREAK: begin
              x_exc  = mrs_pkg::EXC_BP;
              x_code = mrs_pkg::CAUSE_BP;
            end
            mrs_pkg::FN_MFHI: x_wr_val = hi_q;
            mrs_pkg::FN_MFLO: x_wr_val = lo_q;
            mrs_pkg::FN_MTHI: begin
              x_wr_reg = '0;
              x_hi_we  = 1'b1;
              x_hi     = a_q;
            end
            mrs_pkg::FN_MTLO: begin
              x_wr_reg = '0;
              x_lo_we  = 1'b1;
              x_lo     = a_q;
            end
            mrs_pkg::FN_MULT, mrs_pkg::FN_MULTU: begin
              x_wr_reg = '0;
              x_hi_we  = 1'b1;
              x_lo_we  = 1'b1;
            end
            mrs_pkg::FN_DIV, mrs_pkg::FN_DIVU: x_wr_reg = '0;
            mrs_pkg::FN_ADD: begin
              x_wr_val = sum;
              if (((a_q ^ sum) & (b_q ^ sum)) >> 31 != '0) begin
                x_exc  = mrs_pkg::EXC_OV;
                x_code = mrs_pkg::CAUSE_OV;
              end
            end
            mrs_pkg::FN_ADDU: x_wr_val = sum;
            mrs_pkg::FN_SUB: begin
              x_wr_val = dif;
              if (((a_q ^ b_q) & (a_q ^ dif)) >> 31 != '0) begin
                x_exc  = mrs_pkg::EXC_OV;
                x_code = mrs_pkg::CAUSE_OV;
              end
            end
            mrs_pkg::FN_SUBU: x_wr_val = dif;
            mrs_pkg::FN_AND:  x_wr_val = a_q & b_q;
            mrs_pkg::FN_OR:   x_wr_val = a_q | b_q;
            mrs_pkg::FN_XOR:  x_wr_val = a_q ^ b_q;
            mrs_pkg::FN_NOR:  x_wr_val = ~(a_q | b_q);
            mrs_pkg::FN_SLT:  x_wr_val = {31'h0, $signed(a_q) < $signed(b_q)};
            mrs_pkg::FN_SLTU: x_wr_val = {31'h0, a_q < b_q};
            default:          x_wr_reg = '0;
          endcase
        end
        mrs_pkg::OP_REGIMM: begin
          x_wr_reg = rt[4] ? mrs_pkg::LINK_REG : 5'd0;
          x_wr_val = pc_q + 32'd8;
          x_nb     = rt[0] ? !a_q[31] : a_q[31];
          x_nt     = npc + (simm << 2);
        end
        mrs_pkg::OP_J, mrs_pkg::OP_JAL: begin
          x_wr_reg = (op == mrs_pkg::OP_JAL) ? mrs_pkg::LINK_REG : 5'd0;
          x_wr_val = pc_q + 32'd8;
          x_nb     = 1'b1;
          x_nt     = (npc & mrs_pkg::PC_HI) | ((ins & mrs_pkg::TGT_MASK) << 2);
        end
        mrs_pkg::OP_BEQ: begin
          x_nb = (a_q == b_q);
          x_nt = npc + (simm << 2);
        end
        mrs_pkg::OP_BNE: begin
          x_nb = (a_q != b_q);
          x_nt = npc + (simm << 2);
        end
        mrs_pkg::OP_BLEZ: begin
          x_nb = (a_q == '0) || a_q[31];
          x_nt = npc + (simm << 2);
        end
        mrs_pkg::OP_BGTZ: begin
          x_nb = (a_q != '0) && !a_q[31];
          x_nt = npc + (simm << 2);
        end
        mrs_pkg::OP_ADDI: begin
          x_wr_reg = rt;
          x_wr_val = r_addi;
          if (((a_q ^ r_addi) & (simm ^ r_addi)) >> 31 != '0) begin
            x_exc  = mrs_pkg::EXC_OV;
            x_code = mrs_pkg::CAUSE_OV;
          end
        end
        mrs_pkg::OP_ADDIU: begin
          x_wr_reg = rt;
          x_wr_val = r_addi;
        end
        mrs_pkg::OP_SLTI: begin
          x_wr_reg = rt;
          x_wr_val = {31'h0, $signed(a_q) < $signed(simm)};
        end
        mrs_pkg::OP_SLTIU: begin
          x_wr_reg = rt;
          x_wr_val = {31'h0, a_q < simm};
        end
        mrs_pkg::OP_ANDI: begin
          x_wr_reg = rt;
          x_wr_val = a_q & imm;
        end
        mrs_pkg::OP_ORI: begin
          x_wr_reg = rt;
          x_wr_val = a_q | imm;
        end
        mrs_pkg::OP_XORI: begin
          x_wr_reg = rt;
          x_wr_val = a_q ^ imm;
        end
        mrs_pkg::OP_LUI: begin
          x_wr_reg = rt;
          x_wr_val = imm << 16;
        end
        mrs_pkg::OP_COP0: begin
          if (rs == mrs_pkg::CO_MF) begin
            x_ld     = 1'b1;
            x_ld_val = cop0_q[rd];
          end else if (rs == mrs_pkg::CO_MT) begin
            x_c0_we = 1'b1;
          end else begin
            x_rfe = 1'b1;
          end
        end
        mrs_pkg::OP_LB, mrs_pkg::OP_LBU: begin
          x_ld     = 1'b1;
          x_ld_val = {24'h0, 8'(word >> lane)};
          if (op == mrs_pkg::OP_LB) begin
            x_ld_val = {{24{x_ld_val[7]}}, x_ld_val[7:0]};
          end
        end
        mrs_pkg::OP_LH, mrs_pkg::OP_LHU: begin
          if (addr_q[0]) begin
            x_exc  = mrs_pkg::EXC_ADEL;
            x_code = mrs_pkg::CAUSE_ADEL;
            x_bad  = 1'b1;
          end
          x_ld     = 1'b1;
          x_ld_val = {16'h0, 16'(word >> lane)};
          if (op == mrs_pkg::OP_LH) begin
            x_ld_val = {{16{x_ld_val[15]}}, x_ld_val[15:0]};
          end
        end
        mrs_pkg::OP_LWL: begin
          x_ld     = 1'b1;
          x_ld_val = (b_q & (32'h00FF_FFFF >> lane)) | (word << lane_l);
        end
        mrs_pkg::OP_LW: begin
          if (addr_q[1:0] != 2'b00) begin
            x_exc  = mrs_pkg::EXC_ADEL;
            x_code = mrs_pkg::CAUSE_ADEL;
            x_bad  = 1'b1;
          end
          x_ld     = 1'b1;
          x_ld_val = word;
        end
        mrs_pkg::OP_LWR: begin
          x_ld     = 1'b1;
          x_ld_val = (b_q & ~(mrs_pkg::ONES >> lane)) | (word >> lane);
        end
        mrs_pkg::OP_SB: begin
          x_st      = 1'b1;
          x_st_data = (word & ~(32'hFF << lane)) | ((b_q & 32'hFF) << lane);
        end
        mrs_pkg::OP_SH: begin
          if (addr_q[0]) begin
            x_exc  = mrs_pkg::EXC_ADES;
            x_code = mrs_pkg::CAUSE_ADES;
            x_bad  = 1'b1;
          end
          x_st      = 1'b1;
          x_st_data = (word & ~(32'hFFFF << lane)) | ((b_q & 32'hFFFF) << lane);
        end
        mrs_pkg::OP_SWL: begin
          x_st      = 1'b1;
          x_st_data = (word & (32'hFFFF_FF00 << lane)) | (b_q >> lane_l);
        end
        mrs_pkg::OP_SW: begin
          if (addr_q[1:0] != 2'b00) begin
            x_exc  = mrs_pkg::EXC_ADES;
            x_code = mrs_pkg::CAUSE_ADES;
            x_bad  = 1'b1;
          end
          x_st      = 1'b1;
          x_st_data = b_q;
        end
        mrs_pkg::OP_SWR: begin
          x_st      = 1'b1;
          x_st_data = (word & ~(mrs_pkg::ONES << lane)) | (b_q << lane);
        end
        default: begin
          x_exc  = mrs_pkg::EXC_RI;
          x_code = mrs_pkg::CAUSE_RI;
        end
      endcase
    end
    // Writes to register zero vanish; a trap drops them all
    if (x_wr_reg == '0 || x_exc != mrs_pkg::EXC_NONE) begin
      x_wr_reg = '0;
      x_wr_val = '0;
    end
    if (x_ld_reg == '0 || x_exc != mrs_pkg::EXC_NONE) begin
      x_ld = 1'b0;
    end
    if (x_exc != mrs_pkg::EXC_NONE) begin
      x_st = 1'b0;
    end
  end

  // Retire the held load unless overwritten directly or a trap is taken
  assign x_apply = lw_q && (ld_reg_q != '0) && (ld_reg_q != x_wr_reg) &&
                   (x_exc == mrs_pkg::EXC_NONE);

  // Exception bookkeeping
  assign cause_new   = ((cop0_q[mrs_pkg::C0_CAUSE] & ~mrs_pkg::CODE_MASK) |
                        ({27'h0, x_code} << 2) | (bw_q ? mrs_pkg::BD_BIT : '0)) &
                       ~(bw_q ? '0 : mrs_pkg::BD_BIT);
  assign status_push = (cop0_q[mrs_pkg::C0_STATUS] & ~mrs_pkg::MODE_MASK) |
                       ((cop0_q[mrs_pkg::C0_STATUS] << 2) & mrs_pkg::MODE_MASK);
  assign status_rfe  = (cop0_q[mrs_pkg::C0_STATUS] & ~32'hF) |
                       ((cop0_q[mrs_pkg::C0_STATUS] >> 2) & 32'hF);
  assign vec         = cop0_q[mrs_pkg::C0_STATUS][mrs_pkg::BEV_BIT] ? mrs_pkg::VEC_BEV
                                                                     : mrs_pkg::VEC_NORM;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mrs_pkg::BK_IDLE: begin
        if (head_valid_i && !out_valid_q) begin
          state_d = mrs_pkg::BK_READ;
        end
      end
      mrs_pkg::BK_READ: state_d = mrs_pkg::BK_EXEC;
      mrs_pkg::BK_EXEC: begin
        if (dec_q.is_div && x_exc == mrs_pkg::EXC_NONE) begin
          state_d = mrs_pkg::BK_DIV;
        end else if (x_apply) begin
          state_d = mrs_pkg::BK_LOADW;
        end else begin
          state_d = mrs_pkg::BK_IDLE;
        end
      end
      mrs_pkg::BK_DIV: begin
        if (div_done) begin
          state_d = ap_q ? mrs_pkg::BK_LOADW : mrs_pkg::BK_IDLE;
        end
      end
      mrs_pkg::BK_LOADW: state_d = mrs_pkg::BK_IDLE;
      default: state_d = mrs_pkg::BK_IDLE;
    endcase
  end

  // Per-state port controls
  always_comb begin
    pop_o      = 1'b0;
    rf_raddr_a = head_i.ins[25:21];
    rf_raddr_b = head_i.ins[20:16];
    dm_raddr   = addr_rd[2 +: DAW];
    dm_we      = 1'b0;
    rf_we      = 1'b0;
    rf_waddr   = x_wr_reg;
    rf_wdata   = x_wr_val;
    div_start  = 1'b0;
    case (state_q)
      mrs_pkg::BK_IDLE: pop_o = head_valid_i && !out_valid_q;
      mrs_pkg::BK_EXEC: begin
        rf_we     = (x_wr_reg != '0);
        dm_we     = x_st;
        div_start = dec_q.is_div && (x_exc == mrs_pkg::EXC_NONE);
      end
      mrs_pkg::BK_LOADW: begin
        rf_we    = 1'b1;
        rf_waddr = ap_reg_q;
        rf_wdata = ap_val_q;
      end
      default: ;
    endcase
  end

  // Architectural state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrs_pkg::BK_IDLE;
      hi_q        <= '0;
      lo_q        <= '0;
      pc_q        <= mrs_pkg::RESET_PC;
      bw_q        <= 1'b0;
      bd_q        <= '0;
      lw_q        <= 1'b0;
      ld_reg_q    <= '0;
      ld_val_q    <= '0;
      ap_q        <= 1'b0;
      rf_vld_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < mrs_pkg::NREGS; i++) begin
        cop0_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (result_o.valid && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      case (state_q)
        mrs_pkg::BK_EXEC: begin
          if (x_exc != mrs_pkg::EXC_NONE) begin
            cop0_q[mrs_pkg::C0_CAUSE]  <= cause_new;
            cop0_q[mrs_pkg::C0_EPC]    <= bw_q ? (pc_q - 32'd4) : pc_q;
            cop0_q[mrs_pkg::C0_STATUS] <= status_push;
            if (x_bad) begin
              cop0_q[mrs_pkg::C0_BADVADDR] <= addr_q;
            end
            pc_q <= vec;
            bw_q <= 1'b0;
            lw_q <= 1'b0;
          end else begin
            if (x_hi_we) begin
              hi_q <= x_hi;
            end
            if (x_lo_we) begin
              lo_q <= x_lo;
            end
            if (x_c0_we) begin
              cop0_q[rd] <= b_q;
            end
            if (x_rfe) begin
              cop0_q[mrs_pkg::C0_STATUS] <= status_rfe;
            end
            ap_q <= x_apply;
            lw_q <= x_ld;
            if (x_ld) begin
              ld_reg_q <= x_ld_reg;
              ld_val_q <= x_ld_val;
            end
            if (bw_q) begin
              pc_q <= bd_q;
              bw_q <= 1'b0;
            end else begin
              pc_q <= npc;
              bw_q <= x_nb;
              bd_q <= x_nt;
            end
          end
          if (!(dec_q.is_div && x_exc == mrs_pkg::EXC_NONE)) begin
            out_valid_q <= 1'b1;
          end
        end
        mrs_pkg::BK_DIV: begin
          if (div_done) begin
            lo_q        <= q_fix;
            hi_q        <= r_fix;
            out_valid_q <= 1'b1;
          end
        end
        mrs_pkg::BK_LOADW: ap_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // Operand and result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dec_q <= head_i;
    end
    if (state_q == mrs_pkg::BK_READ) begin
      a_q    <= a_rd;
      b_q    <= b_rd;
      addr_q <= addr_rd;
      if (dec_q.is_mul) begin
        prod_q <= prod_full[63:0];
      end
    end
    if (state_q == mrs_pkg::BK_EXEC) begin
      ap_reg_q  <= ld_reg_q;
      ap_val_q  <= ld_val_q;
      o_kind_q  <= x_exc;
      o_reg_q   <= x_wr_reg;
      o_val_q   <= x_wr_val;
      o_st_q    <= x_st;
      o_saddr_q <= x_st ? {addr_q[31:2], 2'b00} : '0;
      o_sdata_q <= x_st ? x_st_data : '0;
      if (x_exc != mrs_pkg::EXC_NONE) begin
        o_pc_q <= vec;
      end else begin
        o_pc_q <= bw_q ? bd_q : npc;
      end
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.fetch_pc       = o_pc_q;
  assign result_o.exception_kind = o_kind_q;
  assign result_o.reg_written    = o_reg_q;
  assign result_o.reg_value      = o_val_q;
  assign result_o.store_valid    = o_st_q;
  assign result_o.store_address  = o_saddr_q;
  assign result_o.store_data     = o_sdata_q;

endmodule

// ===== hw/rtl/mips_r3000_instruction_step.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Beat payload
// item_i    in   instruction_word
// result_o  out  fetch_pc, exception_kind, reg_written, reg_value,
//                store_valid, store_address, store_data
//
// An instruction passes through the back end in register read, memory read
// and execute steps, plus a step when a held load retires into the register
// file; DIV/DIVU also wait on the divider, which runs one quotient bit a cycle.
// The front accepts and classifies into a two-deep queue while the back
// works; a new instruction starts once the previous result has been taken.
// Reset puts PC at the boot vector and clears registers; data RAM is not cleared.

module mips_r3000_instruction_step #(
  parameter int unsigned DATA_WORDS = mrs_pkg::DATA_WORDS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrs_in_if.sink    item_i,
  mrs_out_if.source result_o
);

  logic          push, pop, full, head_valid;
  mrs_pkg::dec_t dec_in, head;

  mrs_front u_front (
    .item_i, .full_i(full), .push_o(push), .dec_o(dec_in)
  );

  mrs_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(dec_in), .pop_i(pop),
    .full_o(full), .valid_o(head_valid), .data_o(head)
  );

  mrs_back #(.DATA_WORDS(DATA_WORDS)) u_back (
    .clk_i, .rst_ni, .head_valid_i(head_valid), .head_i(head), .pop_o(pop), .result_o
  );

endmodule
